### sv/pcc_pkg.sv
// Shared constants, codes and control types for the pairwise contact counter.
// Used by the controller, the datapath, the top level and the port checker.
// No dependencies.
package pcc_pkg;

    // Array sizes
    localparam int AGENTS      = 256;
    localparam int COUNT_BITS  = 16;
    localparam int AGENT_BITS  = $clog2(AGENTS);
    localparam int N_BITS      = $clog2(AGENTS + 1);
    localparam int PAIR_SLOTS  = AGENTS * (AGENTS - 1) / 2;
    localparam int SLOT_BITS   = $clog2(PAIR_SLOTS + 1);

    // Field widths of the request and result
    localparam int REQ_BITS    = 2;
    localparam int AFIELD_BITS = 8;
    localparam int COORD_BITS  = 20;
    localparam int POS_BITS    = 2 * COORD_BITS;
    localparam int DIFF_BITS   = COORD_BITS + 1;
    localparam int SQ_BITS     = 2 * COORD_BITS;
    localparam int OUT_BITS    = 16;
    localparam int IN_DATA_BITS  = 56;
    localparam int OUT_DATA_BITS = 16;

    // Configuration registers
    localparam int RADIUS_BITS    = 40;
    localparam int ACTIVE_BITS    = 9;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 40;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RADIUS = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ACTIVE = 1'b1;
    localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = RADIUS_BITS'(65536);
    localparam logic [ACTIVE_BITS-1:0] ACTIVE_RESET = ACTIVE_BITS'(256);

    // Request kinds
    localparam logic [REQ_BITS-1:0] REQ_LOAD  = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_CLOSE = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_READ  = 2'd2;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PIVOT_RD,
        ST_PIVOT_CHK,
        ST_WALK,
        ST_NEXT,
        ST_DRAIN,
        ST_RD_MUL,
        ST_RD_SLOT,
        ST_RD_ISSUE,
        ST_RD_DATA
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic                  pos_wr;
        logic                  req_latch;
        logic                  pos_rd;
        logic [AGENT_BITS-1:0] pos_rd_addr;
        logic                  pivot_latch;
        logic                  pair_issue;
        logic [SLOT_BITS-1:0]  slot;
        logic                  cnt_clear;
        logic                  rd_issue;
        logic                  out_load;
        logic                  flags_clear;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic pivot_present;
        logic pipe_busy;
        logic out_busy;
    } dp_status_t;

endpackage

### sv/pcc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Holds its read data when no read is requested. No dependencies.
module pcc_ram #(
    parameter int WIDTH     = 16,
    parameter int DEPTH     = 256,
    parameter int ADDR_BITS = 8
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### sv/pcc_ctrl.sv
// Sequencer for the contact counter: clearing pass, request decode, pair walk
// and read sequencing. Depends on pcc_pkg; drives pcc_dpath by command struct.
module pcc_ctrl (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic [pcc_pkg::REQ_BITS-1:0]       in_req,
    output logic                               in_ready,
    input  logic                               cfg_we,
    input  logic [pcc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [pcc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  pcc_pkg::dp_status_t                status,
    output pcc_pkg::ctrl_cmd_t                 cmd
);

    pcc_pkg::state_t                    state_reg, state_next;
    logic [pcc_pkg::N_BITS-1:0]         hi_reg, hi_next;
    logic [pcc_pkg::AGENT_BITS-1:0]     lo_reg, lo_next;
    logic [pcc_pkg::SLOT_BITS-1:0]      base_reg, base_next;
    logic [pcc_pkg::SLOT_BITS-1:0]      clr_reg, clr_next;
    logic [pcc_pkg::ACTIVE_BITS-1:0]    active_reg;
    logic [pcc_pkg::N_BITS-1:0]         n_lim;

    // Agents taking part in a close, limited to the array size
    assign n_lim = (int'(active_reg) > pcc_pkg::AGENTS) ?
                   pcc_pkg::N_BITS'(pcc_pkg::AGENTS) : pcc_pkg::N_BITS'(active_reg);

    // Active agent count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= pcc_pkg::ACTIVE_RESET;
        end
        else if (cfg_we && cfg_index == pcc_pkg::CFG_ACTIVE)
        begin
            active_reg <= cfg_data[pcc_pkg::ACTIVE_BITS-1:0];
        end
    end

    // State and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pcc_pkg::ST_CLEAR;
            hi_reg    <= '0;
            lo_reg    <= '0;
            base_reg  <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            hi_reg    <= hi_next;
            lo_reg    <= lo_next;
            base_reg  <= base_next;
            clr_reg   <= clr_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        base_next  = base_reg;
        clr_next   = clr_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            pcc_pkg::ST_CLEAR:
            begin
                // Zero one count entry per cycle after reset
                cmd.cnt_clear = 1'b1;
                cmd.slot      = clr_reg;
                if (clr_reg == pcc_pkg::SLOT_BITS'(pcc_pkg::PAIR_SLOTS - 1))
                begin
                    state_next = pcc_pkg::ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + pcc_pkg::SLOT_BITS'(1);
                end
            end
            pcc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (in_req)
                        pcc_pkg::REQ_LOAD:
                        begin
                            cmd.pos_wr = 1'b1;
                        end
                        pcc_pkg::REQ_CLOSE:
                        begin
                            hi_next   = pcc_pkg::N_BITS'(1);
                            base_next = '0;
                            if (n_lim < pcc_pkg::N_BITS'(2))
                            begin
                                state_next = pcc_pkg::ST_DRAIN;
                            end
                            else
                            begin
                                state_next = pcc_pkg::ST_PIVOT_RD;
                            end
                        end
                        pcc_pkg::REQ_READ:
                        begin
                            cmd.req_latch = 1'b1;
                            state_next    = pcc_pkg::ST_RD_MUL;
                        end
                        default:
                        begin
                            // drop unknown requests
                        end
                    endcase
                end
            end
            pcc_pkg::ST_PIVOT_RD:
            begin
                cmd.pos_rd      = 1'b1;
                cmd.pos_rd_addr = hi_reg[pcc_pkg::AGENT_BITS-1:0];
                state_next      = pcc_pkg::ST_PIVOT_CHK;
            end
            pcc_pkg::ST_PIVOT_CHK:
            begin
                // Skip the row when the higher agent is absent
                cmd.pivot_latch = 1'b1;
                lo_next         = '0;
                if (status.pivot_present)
                begin
                    state_next = pcc_pkg::ST_WALK;
                end
                else
                begin
                    state_next = pcc_pkg::ST_NEXT;
                end
            end
            pcc_pkg::ST_WALK:
            begin
                // Issue one pair per cycle against the latched pivot
                cmd.pair_issue  = 1'b1;
                cmd.pos_rd      = 1'b1;
                cmd.pos_rd_addr = lo_reg;
                cmd.slot        = base_reg + pcc_pkg::SLOT_BITS'(lo_reg);
                if (lo_reg == pcc_pkg::AGENT_BITS'(hi_reg - pcc_pkg::N_BITS'(1)))
                begin
                    state_next = pcc_pkg::ST_NEXT;
                end
                else
                begin
                    lo_next = lo_reg + pcc_pkg::AGENT_BITS'(1);
                end
            end
            pcc_pkg::ST_NEXT:
            begin
                if (hi_reg == n_lim - pcc_pkg::N_BITS'(1))
                begin
                    state_next = pcc_pkg::ST_DRAIN;
                end
                else
                begin
                    base_next  = base_reg + pcc_pkg::SLOT_BITS'(hi_reg);
                    hi_next    = hi_reg + pcc_pkg::N_BITS'(1);
                    state_next = pcc_pkg::ST_PIVOT_RD;
                end
            end
            pcc_pkg::ST_DRAIN:
            begin
                // Let the last pairs retire, then end the frame
                if (!status.pipe_busy)
                begin
                    cmd.flags_clear = 1'b1;
                    state_next      = pcc_pkg::ST_IDLE;
                end
            end
            pcc_pkg::ST_RD_MUL:
            begin
                state_next = pcc_pkg::ST_RD_SLOT;
            end
            pcc_pkg::ST_RD_SLOT:
            begin
                state_next = pcc_pkg::ST_RD_ISSUE;
            end
            pcc_pkg::ST_RD_ISSUE:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = pcc_pkg::ST_RD_DATA;
            end
            pcc_pkg::ST_RD_DATA:
            begin
                // Hold the count until the output register is free
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = pcc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pcc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### sv/pcc_dpath.sv
// Datapath for the contact counter: position and count memories, presence
// flags, distance pipeline, pair read path and output register.
// Depends on pcc_pkg and pcc_ram; commanded by pcc_ctrl.
module pcc_dpath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pcc_pkg::ctrl_cmd_t                  cmd,
    output pcc_pkg::dp_status_t                 status,
    input  logic                                cfg_we,
    input  logic [pcc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [pcc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic [pcc_pkg::AFIELD_BITS-1:0]     agent_a,
    input  logic [pcc_pkg::AFIELD_BITS-1:0]     agent_b,
    input  logic signed [pcc_pkg::COORD_BITS-1:0] x_pos,
    input  logic signed [pcc_pkg::COORD_BITS-1:0] y_pos,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [pcc_pkg::OUT_BITS-1:0]        pair_count
);

    localparam int WIDE_BITS = pcc_pkg::AGENT_BITS + pcc_pkg::AFIELD_BITS;

    logic [WIDE_BITS-1:0]                  a_wide, b_wide;
    logic                                  a_ok, b_ok;
    logic [pcc_pkg::AGENT_BITS-1:0]        a_idx, b_idx;

    logic [pcc_pkg::RADIUS_BITS-1:0]       radius_reg;
    logic [pcc_pkg::AGENTS-1:0]            flags_reg;
    logic                                  flag_q_reg;

    logic                                  pos_wr_en;
    logic [pcc_pkg::POS_BITS-1:0]          pos_q;
    logic signed [pcc_pkg::COORD_BITS-1:0] pos_x, pos_y;
    logic                                  pos_live;
    logic signed [pcc_pkg::COORD_BITS-1:0] piv_x_reg, piv_y_reg;

    logic                                  cnt_wr_en, cnt_rd_en;
    logic [pcc_pkg::SLOT_BITS-1:0]         cnt_wr_addr, cnt_rd_addr;
    logic [pcc_pkg::COUNT_BITS-1:0]        cnt_wr_data, cnt_q;

    // Pipeline registers
    logic                                  p1_valid_reg;
    logic [pcc_pkg::SLOT_BITS-1:0]         p1_slot_reg;
    logic                                  p2_valid_reg;
    logic [pcc_pkg::SLOT_BITS-1:0]         p2_slot_reg;
    logic [pcc_pkg::COUNT_BITS-1:0]        p2_count_reg;
    logic signed [pcc_pkg::DIFF_BITS-1:0]  dx_reg, dy_reg;
    logic                                  p3_valid_reg;
    logic [pcc_pkg::SLOT_BITS-1:0]         p3_slot_reg;
    logic [pcc_pkg::COUNT_BITS-1:0]        p3_count_reg;
    logic [pcc_pkg::SQ_BITS-1:0]           sqx_reg, sqy_reg;
    logic                                  p4_valid_reg;
    logic [pcc_pkg::SLOT_BITS-1:0]         p4_slot_reg;
    logic [pcc_pkg::COUNT_BITS-1:0]        p4_count_reg;

    logic signed [2*pcc_pkg::DIFF_BITS-1:0] dx_sq, dy_sq;
    logic [pcc_pkg::SQ_BITS:0]             dist_sq;
    logic                                  hit;

    // Pair read path
    logic [pcc_pkg::AGENT_BITS-1:0]        rd_a_reg, rd_b_reg;
    logic                                  rd_ok_reg;
    logic [pcc_pkg::AGENT_BITS-1:0]        rd_hi, rd_lo;
    logic [2*pcc_pkg::AGENT_BITS-1:0]      rd_prod_reg;
    logic [pcc_pkg::SLOT_BITS-1:0]         rd_slot_reg;

    logic [pcc_pkg::COUNT_BITS+pcc_pkg::OUT_BITS-1:0] cnt_wide;
    logic                                  out_valid_reg;
    logic [pcc_pkg::OUT_BITS-1:0]          out_data_reg;

    // Agent range checks
    assign a_wide = WIDE_BITS'(agent_a);
    assign b_wide = WIDE_BITS'(agent_b);
    assign a_ok   = a_wide < WIDE_BITS'(pcc_pkg::AGENTS);
    assign b_ok   = b_wide < WIDE_BITS'(pcc_pkg::AGENTS);
    assign a_idx  = a_wide[pcc_pkg::AGENT_BITS-1:0];
    assign b_idx  = b_wide[pcc_pkg::AGENT_BITS-1:0];

    // Radius register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= pcc_pkg::RADIUS_RESET;
        end
        else if (cfg_we && cfg_index == pcc_pkg::CFG_RADIUS)
        begin
            radius_reg <= cfg_data[pcc_pkg::RADIUS_BITS-1:0];
        end
    end

    // Presence flags: set on load, clear at frame end
    assign pos_wr_en = cmd.pos_wr && a_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else if (cmd.flags_clear)
        begin
            flags_reg <= '0;
        end
        else if (pos_wr_en)
        begin
            flags_reg[a_idx] <= 1'b1;
        end
    end

    // Position store
    pcc_ram #(
        .WIDTH     (pcc_pkg::POS_BITS),
        .DEPTH     (pcc_pkg::AGENTS),
        .ADDR_BITS (pcc_pkg::AGENT_BITS)
    ) u_pos_ram (
        .clk     (clk),
        .wr_en   (pos_wr_en),
        .wr_addr (a_idx),
        .wr_data ({y_pos, x_pos}),
        .rd_en   (cmd.pos_rd),
        .rd_addr (cmd.pos_rd_addr),
        .rd_data (pos_q)
    );

    // Flag travels with the position read
    always_ff @(posedge clk)
    begin
        if (cmd.pos_rd)
        begin
            flag_q_reg <= flags_reg[cmd.pos_rd_addr];
        end
    end

    assign pos_x    = pos_q[pcc_pkg::COORD_BITS-1:0];
    assign pos_y    = pos_q[pcc_pkg::POS_BITS-1:pcc_pkg::COORD_BITS];
    assign pos_live = flag_q_reg && (pos_x != '0) && (pos_y != '0);

    // Latch the higher agent of the current row
    always_ff @(posedge clk)
    begin
        if (cmd.pivot_latch)
        begin
            piv_x_reg <= pos_x;
            piv_y_reg <= pos_y;
        end
    end

    // Pair count store
    assign cnt_rd_en   = cmd.pair_issue || cmd.rd_issue;
    assign cnt_rd_addr = cmd.rd_issue ? rd_slot_reg : cmd.slot;
    assign cnt_wr_en   = cmd.cnt_clear || p4_valid_reg;
    assign cnt_wr_addr = cmd.cnt_clear ? cmd.slot : p4_slot_reg;
    assign cnt_wr_data = cmd.cnt_clear ? '0 : p4_count_reg + pcc_pkg::COUNT_BITS'(1);

    pcc_ram #(
        .WIDTH     (pcc_pkg::COUNT_BITS),
        .DEPTH     (pcc_pkg::PAIR_SLOTS),
        .ADDR_BITS (pcc_pkg::SLOT_BITS)
    ) u_cnt_ram (
        .clk     (clk),
        .wr_en   (cnt_wr_en),
        .wr_addr (cnt_wr_addr),
        .wr_data (cnt_wr_data),
        .rd_en   (cnt_rd_en),
        .rd_addr (cnt_rd_addr),
        .rd_data (cnt_q)
    );

    // Distance arithmetic
    assign dx_sq   = dx_reg * dx_reg;
    assign dy_sq   = dy_reg * dy_reg;
    assign dist_sq = (pcc_pkg::SQ_BITS+1)'(sqx_reg) + (pcc_pkg::SQ_BITS+1)'(sqy_reg);
    assign hit     = dist_sq < (pcc_pkg::SQ_BITS+1)'(radius_reg);

    // Pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= cmd.pair_issue;
            p2_valid_reg <= p1_valid_reg && pos_live;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg && hit && (p3_count_reg != pcc_pkg::COUNT_MAX);
        end
    end

    // Pipeline payload: differences, squares, then compare
    always_ff @(posedge clk)
    begin
        p1_slot_reg  <= cmd.slot;
        p2_slot_reg  <= p1_slot_reg;
        p2_count_reg <= cnt_q;
        dx_reg       <= pcc_pkg::DIFF_BITS'(pos_x) - pcc_pkg::DIFF_BITS'(piv_x_reg);
        dy_reg       <= pcc_pkg::DIFF_BITS'(pos_y) - pcc_pkg::DIFF_BITS'(piv_y_reg);
        p3_slot_reg  <= p2_slot_reg;
        p3_count_reg <= p2_count_reg;
        sqx_reg      <= dx_sq[pcc_pkg::SQ_BITS-1:0];
        sqy_reg      <= dy_sq[pcc_pkg::SQ_BITS-1:0];
        p4_slot_reg  <= p3_slot_reg;
        p4_count_reg <= p3_count_reg;
    end

    // Pair read: latch agents, then slot = hi*(hi-1)/2 + lo
    assign rd_hi = (rd_a_reg > rd_b_reg) ? rd_a_reg : rd_b_reg;
    assign rd_lo = (rd_a_reg > rd_b_reg) ? rd_b_reg : rd_a_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.req_latch)
        begin
            rd_a_reg  <= a_idx;
            rd_b_reg  <= b_idx;
            rd_ok_reg <= a_ok && b_ok && (agent_a != agent_b);
        end
        rd_prod_reg <= rd_hi * (rd_hi - pcc_pkg::AGENT_BITS'(1));
        rd_slot_reg <= pcc_pkg::SLOT_BITS'(rd_prod_reg >> 1) + pcc_pkg::SLOT_BITS'(rd_lo);
    end

    // Output register
    assign cnt_wide = (pcc_pkg::COUNT_BITS+pcc_pkg::OUT_BITS)'(cnt_q);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= rd_ok_reg ? cnt_wide[pcc_pkg::OUT_BITS-1:0] : '0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pair_count = out_data_reg;

    // Status back to the controller
    always_comb
    begin
        status.pivot_present = pos_live;
        status.pipe_busy     = p1_valid_reg || p2_valid_reg || p3_valid_reg || p4_valid_reg;
        status.out_busy      = out_valid_reg && !out_ready;
    end

endmodule

### sv/pairwise_contact_counter.sv
// Pairwise contact counter. Load requests store an agent position. A close
// request walks every pair of the first active_agents agents whose higher agent
// is present through the distance pipeline, one pair per cycle within a row from
// the position RAM read port, with a pivot read and check before each row and a
// drain at the end of the frame. A read request takes the slot multiply and the
// count RAM read before its result enters the output register; the next request
// is accepted while that result waits. After reset the count RAM is cleared one
// entry per cycle, all 32 640 entries, during which no request is accepted;
// configuration writes are taken at any time.
// Depends on pcc_pkg, pcc_ctrl, pcc_dpath and pcc_ram.
module pairwise_contact_counter (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // agent_a [7:0], agent_b [15:8], x_pos [35:16], y_pos [55:36]
    input  logic [pcc_pkg::IN_DATA_BITS-1:0]      s_axis_tdata,
    // req_type [1:0]
    input  logic [pcc_pkg::REQ_BITS-1:0]          s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // pair_count [15:0]
    output logic [pcc_pkg::OUT_DATA_BITS-1:0]     m_axis_tdata,
    input  logic                                  cfg_we,
    input  logic [pcc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [pcc_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    pcc_pkg::ctrl_cmd_t  cmd;
    pcc_pkg::dp_status_t status;

    pcc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_req    (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (status),
        .cmd       (cmd)
    );

    pcc_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .agent_a    (s_axis_tdata[7:0]),
        .agent_b    (s_axis_tdata[15:8]),
        .x_pos      (s_axis_tdata[35:16]),
        .y_pos      (s_axis_tdata[55:36]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .pair_count (m_axis_tdata)
    );

endmodule

### sv/pcc_checker.sv
// Port-level checks for the pairwise contact counter, bound to the top level.
// Depends on pcc_pkg.
module pcc_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic [pcc_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
    input logic [pcc_pkg::REQ_BITS-1:0]      s_axis_tuser,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [pcc_pkg::OUT_DATA_BITS-1:0] m_axis_tdata
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed or dropped");

    // A new result is only loaded while requests are held off
    a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared outside a read sequence");

    // A read or a close occupies the block for at least the next cycle
    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready &&
        (s_axis_tuser == pcc_pkg::REQ_READ || s_axis_tuser == pcc_pkg::REQ_CLOSE)
        |=> !s_axis_tready)
        else $error("request taken while a read or close was in progress");

    // A load does not stall the input
    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == pcc_pkg::REQ_LOAD
        |=> s_axis_tready)
        else $error("load request stalled the input");

    // Requests that cause no work leave the block ready
    a_results_only_reads: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready && $past(s_axis_tready) |->
        $past(s_axis_tvalid) &&
        ($past(s_axis_tuser) == pcc_pkg::REQ_READ || $past(s_axis_tuser) == pcc_pkg::REQ_CLOSE))
        else $error("input stalled without a read or close request");

endmodule

bind pairwise_contact_counter pcc_checker u_pcc_checker (.*);
